FILE: design/sle_pkg.sv
`default_nettype none

// Shared sizes and request codes for the ordered list engine.
package sle_pkg;

    // Number of entries that the list can hold.
    localparam int CAPACITY = 128;

    localparam int DATA_W = 8;
    localparam int POS_W  = 8;
    localparam int REQ_W  = 3;
    localparam int LEN_W  = 8;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Width used to compare a position against the length without overflow.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int S_FIELDS_W = POS_W + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int M_FIELDS_W = DATA_W + LEN_W + LEN_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET    = 3'd0,
        REQ_LOCATE = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_type_t;

endpackage

`default_nettype wire

FILE: design/sle_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/sequential_list_engine.sv
`default_nettype none

// Ordered list engine. The block keeps up to CAPACITY bytes in order, with
// positions counted from 1, and serves one request at a time: get, locate,
// insert, delete or clear. Each accepted request gives exactly one result
// with a status bit (set for a bad position, a full list on insert, or an
// unknown request kind), the byte read by get, the position found by locate
// (0 when absent), and the length and empty flag after the request. The
// entries live in one single-port-read RAM, and a small sequencer walks it
// one entry per cycle: locate reads from the front until the first match,
// insert copies the tail up by one starting from the end, and delete copies
// the tail down by one. Clear, a rejected request and removing the last
// entry go straight to the output register; an append writes the new byte
// first; get reads its entry, locate and delete walk the RAM, and insert
// moves the tail and then writes the new byte, each before the output
// register is loaded. s_tready returns together with the loading of the
// result into the output register. The longest walks are a locate over a
// full list and an insert at the front of a list holding CAPACITY - 1
// entries. s_tready is high only while no request is in progress. The
// finished result sits in an output register, so the next request can be
// taken and worked on while the previous result still waits for m_tready.
module sequential_list_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [7:0] position, [15:8] value.
    input  wire logic [sle_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] req_type.
    input  wire logic [sle_pkg::REQ_W-1:0]     s_tuser,

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] read_value, [15:8] found_position, [23:16] list_length,
    // [24] list_empty, upper bits zero.
    output logic      [sle_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] status.
    output logic                               m_tuser
);

    import sle_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PUT,
        ST_OUT
    } state_t;

    // Sequencer and list state.
    state_t             state_reg,    state_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [REQ_W-1:0]   op_reg,       op_next;
    logic [DATA_W-1:0]  val_reg,      val_next;
    logic [ADDR_W-1:0]  put_addr_reg, put_addr_next;
    logic [ADDR_W-1:0]  rd_ptr_reg,   rd_ptr_next;
    logic [ADDR_W-1:0]  end_ptr_reg,  end_ptr_next;
    logic [ADDR_W-1:0]  src_reg,      src_next;
    logic               down_reg,     down_next;
    logic               issue_reg,    issue_next;
    logic               pend_reg,     pend_next;

    // Result of the request in progress.
    logic               res_status_reg, res_status_next;
    logic [DATA_W-1:0]  res_read_reg,   res_read_next;
    logic [LEN_W-1:0]   res_found_reg,  res_found_next;

    // Output register.
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_status_reg, m_status_next;
    logic [DATA_W-1:0]  m_read_reg,   m_read_next;
    logic [LEN_W-1:0]   m_found_reg,  m_found_next;
    logic [LEN_W-1:0]   m_len_reg,    m_len_next;
    logic               m_empty_reg,  m_empty_next;

    // RAM port signals.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [DATA_W-1:0]  ram_rdata;

    // Decoded request fields and the range checks on the position.
    logic [POS_W-1:0]   in_pos;
    logic [DATA_W-1:0]  in_val;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   cnt_x;
    logic [CMP_W-1:0]   posm1_x;
    logic [CMP_W-1:0]   cntm1_x;
    logic               rd_ok;
    logic               ins_ok;

    sle_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_val  = s_tdata[POS_W +: DATA_W];
    assign pos_x   = CMP_W'(in_pos);
    assign cnt_x   = CMP_W'(count_reg);
    assign posm1_x = pos_x - CMP_W'(1);
    assign cntm1_x = cnt_x - CMP_W'(1);

    // Get and delete need 1 <= position <= length. Insert needs
    // 1 <= position <= length + 1 and room for one more entry.
    assign rd_ok  = (in_pos != '0) && (pos_x <= cnt_x);
    assign ins_ok = (in_pos != '0) && (pos_x <= cnt_x + CMP_W'(1))
                    && (cnt_x < CMP_W'(CAPACITY));

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        put_addr_next   = put_addr_reg;
        rd_ptr_next     = rd_ptr_reg;
        end_ptr_next    = end_ptr_reg;
        src_next        = src_reg;
        down_next       = down_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        res_found_next  = res_found_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_read_next     = m_read_reg;
        m_found_next    = m_found_reg;
        m_len_next      = m_len_reg;
        m_empty_next    = m_empty_reg;
        ram_we          = 1'b0;
        ram_waddr       = src_reg;
        ram_wdata       = ram_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_tuser;
                    val_next        = in_val;
                    put_addr_next   = posm1_x[ADDR_W-1:0];
                    res_status_next = 1'b0;
                    res_read_next   = '0;
                    res_found_next  = '0;
                    issue_next      = 1'b1;
                    pend_next       = 1'b0;
                    down_next       = 1'b0;
                    state_next      = ST_OUT;
                    unique case (s_tuser)
                        REQ_GET: begin
                            if (rd_ok) begin
                                rd_ptr_next  = posm1_x[ADDR_W-1:0];
                                end_ptr_next = posm1_x[ADDR_W-1:0];
                                state_next   = ST_WALK;
                            end else begin
                                res_status_next = 1'b1;
                            end
                        end
                        REQ_LOCATE: begin
                            // An empty list answers at once with position 0.
                            if (count_reg != '0) begin
                                rd_ptr_next  = '0;
                                end_ptr_next = cntm1_x[ADDR_W-1:0];
                                state_next   = ST_WALK;
                            end
                        end
                        REQ_INSERT: begin
                            if (!ins_ok) begin
                                res_status_next = 1'b1;
                            end else if (pos_x == cnt_x + CMP_W'(1)) begin
                                // Appending needs no move of the tail.
                                state_next = ST_PUT;
                            end else begin
                                rd_ptr_next  = cntm1_x[ADDR_W-1:0];
                                end_ptr_next = posm1_x[ADDR_W-1:0];
                                down_next    = 1'b1;
                                state_next   = ST_WALK;
                            end
                        end
                        REQ_DELETE: begin
                            if (!rd_ok) begin
                                res_status_next = 1'b1;
                            end else if (pos_x == cnt_x) begin
                                // Removing the last entry only shortens the list.
                                count_next = count_reg - CNT_W'(1);
                            end else begin
                                rd_ptr_next  = pos_x[ADDR_W-1:0];
                                end_ptr_next = cntm1_x[ADDR_W-1:0];
                                state_next   = ST_WALK;
                            end
                        end
                        REQ_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            res_status_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                // Read side: issue one address a cycle until the end pointer.
                if (issue_reg) begin
                    pend_next = 1'b1;
                    src_next  = rd_ptr_reg;
                    if (rd_ptr_reg == end_ptr_reg) begin
                        issue_next = 1'b0;
                    end else if (down_reg) begin
                        rd_ptr_next = rd_ptr_reg - ADDR_W'(1);
                    end else begin
                        rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                end

                // Data side: the entry at src_reg is on the RAM output.
                if (pend_reg) begin
                    case (op_reg)
                        REQ_GET: begin
                            res_read_next = ram_rdata;
                        end
                        REQ_LOCATE: begin
                            if (ram_rdata == val_reg) begin
                                res_found_next = LEN_W'(CMP_W'(src_reg) + CMP_W'(1));
                                issue_next     = 1'b0;
                                pend_next      = 1'b0;
                                state_next     = ST_OUT;
                            end
                        end
                        REQ_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = src_reg + ADDR_W'(1);
                        end
                        REQ_DELETE: begin
                            ram_we    = 1'b1;
                            ram_waddr = src_reg - ADDR_W'(1);
                        end
                        default: begin
                        end
                    endcase

                    // The last entry of the walk has just been handled.
                    if (!issue_reg) begin
                        if (op_reg == REQ_INSERT) begin
                            state_next = ST_PUT;
                        end else begin
                            state_next = ST_OUT;
                        end
                        if (op_reg == REQ_DELETE) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
            end

            ST_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = put_addr_reg;
                ram_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_read_next   = res_read_reg;
                    m_found_next  = res_found_reg;
                    m_len_next    = LEN_W'(cnt_x);
                    m_empty_next  = (count_reg == '0);
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg         <= op_next;
        val_reg        <= val_next;
        put_addr_reg   <= put_addr_next;
        rd_ptr_reg     <= rd_ptr_next;
        end_ptr_reg    <= end_ptr_next;
        src_reg        <= src_next;
        down_reg       <= down_next;
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
        res_found_reg  <= res_found_next;
        m_status_reg   <= m_status_next;
        m_read_reg     <= m_read_next;
        m_found_reg    <= m_found_next;
        m_len_reg      <= m_len_next;
        m_empty_reg    <= m_empty_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_empty_reg, m_len_reg, m_found_reg, m_read_reg};

endmodule

`default_nettype wire

FILE: tb/sv/sequential_list_checker.sv
// Watches both channels of the list engine, keeps a shadow copy of the list,
// and compares every result with the prediction for the oldest request.
module sequential_list_checker
    import sle_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [REQ_W-1:0]     s_tuser,

    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tuser,

    output int                        fail_count,
    output int                        outstanding,
    output int                        model_length
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]  found_position;
        logic [LEN_W-1:0]  list_length;
        logic              list_empty;
    } list_result_t;

    logic [DATA_W-1:0] shadow_entries [CAPACITY];
    int                shadow_count;
    list_result_t      awaited_results [$];

    // Applies one request to the shadow list and returns the result it gives.
    function automatic list_result_t apply_list_request(input logic [REQ_W-1:0]  kind,
                                                        input logic [POS_W-1:0]  pos,
                                                        input logic [DATA_W-1:0] val);
        list_result_t res;
        int p;
        int k;
        res = '0;
        p = int'(pos);
        case (kind)
            REQ_GET: begin
                if (p < 1 || p > shadow_count) begin
                    res.status = 1'b1;
                end else begin
                    res.read_value = shadow_entries[p-1];
                end
            end
            REQ_LOCATE: begin
                for (k = 0; k < shadow_count && res.found_position == '0; k++) begin
                    if (shadow_entries[k] == val) begin
                        res.found_position = LEN_W'(k + 1);
                    end
                end
            end
            REQ_INSERT: begin
                if (p < 1 || p > shadow_count + 1 || shadow_count >= CAPACITY) begin
                    res.status = 1'b1;
                end else begin
                    for (k = shadow_count; k >= p; k--) begin
                        shadow_entries[k] = shadow_entries[k-1];
                    end
                    shadow_entries[p-1] = val;
                    shadow_count++;
                end
            end
            REQ_DELETE: begin
                if (p < 1 || p > shadow_count) begin
                    res.status = 1'b1;
                end else begin
                    for (k = p; k < shadow_count; k++) begin
                        shadow_entries[k-1] = shadow_entries[k];
                    end
                    shadow_count--;
                end
            end
            REQ_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
                res.status = 1'b1;
            end
        endcase
        res.list_length = LEN_W'(shadow_count);
        res.list_empty  = (shadow_count == 0);
        return res;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        list_result_t want;
        if (!aresetn) begin
            awaited_results.delete();
            shadow_count = 0;
            fail_count = 0;
            foreach (shadow_entries[i]) begin
                shadow_entries[i] = '0;
            end
        end else begin
            // The result leaving now belongs to an earlier request, so it is
            // matched before the request arriving at this edge is queued.
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result arrived with no request waiting for it");
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, m_tuser);
                    compare_field("read_value", want.read_value, m_tdata[0 +: DATA_W]);
                    compare_field("found_position", want.found_position,
                                  m_tdata[DATA_W +: LEN_W]);
                    compare_field("list_length", want.list_length,
                                  m_tdata[DATA_W + LEN_W +: LEN_W]);
                    compare_field("list_empty", want.list_empty,
                                  m_tdata[DATA_W + 2 * LEN_W]);
                    compare_field("tdata padding", 0, int'(m_tdata >> M_FIELDS_W));
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_list_request(s_tuser, s_tdata[0 +: POS_W],
                                                             s_tdata[POS_W +: DATA_W]));
            end
        end
        outstanding  = awaited_results.size();
        model_length = shadow_count;
    end

endmodule

FILE: tb/sv/sequential_list_engine_test.sv
// Top of the list engine test. It makes the request stream, paces the result
// side, and gives the verdict; all prediction and checking happens in the
// checker instance that sits beside the engine and watches both channels.
module sequential_list_engine_test
    import sle_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Number of random requests after the directed opening.
    localparam int RANDOM_REQUESTS = 1400;

    // The worst request walks the whole list. Even
    // with every request at that length, plus the gaps on both sides and the
    // long hold-off, a correct run stays far below this limit.
    localparam int LIMIT_CYCLES = 1_000_000;

    // The long hold-off of the receiver, and the stretch of requests during
    // which neither side idles.
    localparam int HOLD_CYCLES     = 600;
    localparam int HOLD_AFTER      = 300;
    localparam int CALM_FIRST      = 700;
    localparam int CALM_LAST       = 850;
    localparam int DRAIN_AT        = 1000;
    localparam int IDLE_PERCENT    = 29;

    // Request kinds above clear are not defined; the engine must reject them.
    localparam int REQ_RSVD_FIRST = int'(REQ_CLEAR) + 1;
    localparam int REQ_RSVD_LAST  = (1 << REQ_W) - 1;

    // How the random requests lean: toward filling the list, emptying it,
    // or an even mix.
    typedef enum {
        MIX_GROW,
        MIX_EVEN,
        MIX_SHRINK
    } request_mix_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire                  m_tuser;

    int fail_count;
    int outstanding;
    int model_length;
    int requests_sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sequential_list_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sequential_list_checker list_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .model_length (model_length)
    );

    // While this stretch of requests is being sent, neither side idles.
    function automatic bit calm_stretch();
        return requests_sent >= CALM_FIRST && requests_sent < CALM_LAST;
    endfunction

    // Offers one request, with random idle cycles ahead of it, and returns at
    // the falling edge after it was taken. The valid line is left high, so a
    // back-to-back request keeps it high without a drop in between.
    task automatic send_request(input logic [REQ_W-1:0]  kind,
                                input logic [POS_W-1:0]  pos,
                                input logic [DATA_W-1:0] val);
        while (!calm_stretch() && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            s_tuser  <= REQ_W'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({val, pos});
        do begin
            @(posedge aclk);
        end while (!s_tready);
        requests_sent++;
        @(negedge aclk);
    endtask

    // Picks one random request. Most are well formed for the current length,
    // so the list really grows to full and shrinks back; a share uses bad
    // positions, and a small share is pure noise in every field. Values come
    // from a narrow range half of the time so that locate finds matches.
    task automatic pick_request(input request_mix_t mix,
                                output logic [REQ_W-1:0]  kind,
                                output logic [POS_W-1:0]  pos,
                                output logic [DATA_W-1:0] val);
        int roll;
        int top_pos;
        roll = $urandom_range(0, 99);
        val  = $urandom_range(0, 1) ? DATA_W'($urandom_range(0, 15)) : DATA_W'($urandom);
        if (roll < 8) begin
            kind = REQ_W'($urandom);
            pos  = POS_W'($urandom);
            return;
        end
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                kind = (roll < 85) ? REQ_INSERT :
                       (roll < 92) ? REQ_GET :
                       (roll < 97) ? REQ_LOCATE : REQ_DELETE;
            end
            MIX_SHRINK: begin
                kind = (roll < 15) ? REQ_INSERT :
                       (roll < 65) ? REQ_DELETE :
                       (roll < 80) ? REQ_GET :
                       (roll < 98) ? REQ_LOCATE : REQ_CLEAR;
            end
            default: begin
                kind = (roll < 40) ? REQ_INSERT :
                       (roll < 65) ? REQ_DELETE :
                       (roll < 82) ? REQ_GET :
                       (roll < 95) ? REQ_LOCATE :
                       (roll < 98) ? REQ_W'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST)) :
                                     REQ_CLEAR;
            end
        endcase
        // The highest good position: one past the end for insert, the last
        // entry for get and delete. With an empty list only bad ones remain.
        top_pos = (kind == REQ_INSERT) ? model_length + 1 : model_length;
        if (top_pos == 0 || $urandom_range(0, 99) < 6) begin
            case ($urandom_range(0, 2))
                0:       pos = '0;
                1:       pos = POS_W'(top_pos + 1);
                default: pos = POS_W'($urandom_range(top_pos + 1, 255));
            endcase
        end else begin
            // Lean toward the two ends, where the shifting walks are longest
            // and shortest.
            case ($urandom_range(0, 3))
                0:       pos = POS_W'(1);
                1:       pos = POS_W'(top_pos);
                default: pos = POS_W'($urandom_range(1, top_pos));
            endcase
        end
    endtask

    // Result side: random back-pressure, one long hold-off while the sender
    // keeps offering so that the engine fills up and stalls its input, and
    // no back-pressure during the calm stretch.
    initial begin
        bit hold_done;
        int held;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!hold_done && requests_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) begin
                    @(negedge aclk);
                end
            end else if (calm_stretch()) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Run limit: a hung engine ends the run here.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [REQ_W-1:0]  kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        request_mix_t      mix;
        int                i;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening, starting from the empty list.
        // Get and delete on an empty list are bad positions, and locate
        // on an empty list finds nothing.
        send_request(REQ_GET,    8'd1,   8'h00);
        send_request(REQ_DELETE, 8'd1,   8'h00);
        send_request(REQ_LOCATE, 8'd0,   8'h00);
        // Insert at position zero and past one beyond the end are rejected.
        send_request(REQ_INSERT, 8'd0,   8'h11);
        send_request(REQ_INSERT, 8'd2,   8'h22);
        // Build the list 5A A5 FF 00 from inserts at the front, the end and
        // the middle, with both extremes of the value.
        send_request(REQ_INSERT, 8'd1,   8'hFF);
        send_request(REQ_INSERT, 8'd2,   8'h00);
        send_request(REQ_INSERT, 8'd1,   8'h5A);
        send_request(REQ_INSERT, 8'd2,   8'hA5);
        // Reads at both ends, one past the end, at zero and at the top code.
        send_request(REQ_GET,    8'd1,   8'h00);
        send_request(REQ_GET,    8'd4,   8'h00);
        send_request(REQ_GET,    8'd5,   8'h00);
        send_request(REQ_GET,    8'd0,   8'h00);
        send_request(REQ_GET,    8'd255, 8'hFF);
        // A match in the last entry, and a value that is absent.
        send_request(REQ_LOCATE, 8'd255, 8'h00);
        send_request(REQ_LOCATE, 8'd0,   8'h77);
        // Delete in the middle, then the last entry, then a bad position.
        send_request(REQ_DELETE, 8'd2,   8'h00);
        send_request(REQ_DELETE, 8'd3,   8'h00);
        send_request(REQ_DELETE, 8'd255, 8'h00);
        // Undefined request kinds are rejected and leave the list alone.
        send_request(REQ_W'(REQ_RSVD_FIRST),     8'd1,   8'hFF);
        send_request(REQ_W'(REQ_RSVD_FIRST + 1), 8'd255, 8'h00);
        send_request(REQ_W'(REQ_RSVD_LAST),      8'd2,   8'hFF);
        // Clear, then confirm the old entries are no longer reachable.
        send_request(REQ_CLEAR,  8'd255, 8'hFF);
        send_request(REQ_GET,    8'd1,   8'h00);
        send_request(REQ_LOCATE, 8'd0,   8'h5A);

        // Random part, in stretches that fill the list to the full case,
        // mix evenly, and empty it again.
        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == DRAIN_AT) begin
                // The sender stops until every result has come back.
                s_tvalid <= 1'b0;
                do begin
                    @(negedge aclk);
                end while (outstanding != 0);
            end
            case ((i / 160) % 4)
                0:       mix = MIX_GROW;
                2:       mix = MIX_SHRINK;
                default: mix = MIX_EVEN;
            endcase
            pick_request(mix, kind, pos, val);
            send_request(kind, pos, val);
        end
        s_tvalid <= 1'b0;

        // Wait for the last results, then long enough for a full walk, so
        // that a stray extra result would still be seen by the checker.
        while (outstanding != 0) begin
            @(negedge aclk);
        end
        repeat (2 * CAPACITY) @(posedge aclk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
